// ===== rtl/core/epbe_pkg.sv =====
// types and constants shared by the equal-population bin edge block
// no dependencies
`default_nettype none
package epbe_pkg;

	localparam int BIN_W = 8;
	localparam int CNT_W = 24;
	localparam int SUM_W = 32;
	localparam int IDX_W = 4;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;
	localparam logic AXIS_ET     = 1'b0;
	localparam logic AXIS_ETA    = 1'b1;
	localparam logic [1:0] CLS_NEUTRINO = 2'd3;

	typedef struct packed {
		logic        func;
		logic [1:0]  obj_class;
		logic [11:0] et_ceil;
		logic [9:0]  eta_ceil;
	} obj_t;

	typedef struct packed {
		logic [1:0]       edge_class;
		logic             edge_axis;
		logic [IDX_W-1:0] edge_index;
		logic [BIN_W-1:0] edge_value;
		logic             last_edge;
	} res_t;

	typedef struct packed {
		logic             func;
		logic [1:0]       obj_class;
		logic [BIN_W-1:0] et_bin;
		logic [BIN_W-1:0] eta_bin;
		logic             eta_en;
	} cmd_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} bstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/equal_population_bin_edges.sv =====
// top level of the equal-population bin edge block
// depends on epbe_pkg, epbe_front, epbe_back (and epbe_ram through it)
`default_nettype none
// Collects per-class Et and |eta| histograms of light jets, b jets, muons and
// neutrinos and, on a finish beat, emits the interior edges that split each
// histogram into NUM_BINS parts of equal population: for each class 0..2 the
// Et edges 1..NUM_BINS-1 and then its eta edges, then the class 3 Et edges,
// 7*(NUM_BINS-1) result beats with last_edge on the final one. An edge is the
// first step whose running sum times NUM_BINS exceeds the edge number times
// the class total, or 0 if none does. Objects above MAX_ET or, except
// neutrinos, above MAX_ETA_STEP are dropped. The front checks and queues beats
// in a two-entry queue; the back owns two histogram rams and the class totals.
// An object's bins are read in the idle state, then written back saturated,
// and the back takes no new command until that write is done. A finish reads
// each of the 4*(MAX_ET+1)+3*(MAX_ETA_STEP+1) bins by a ram read, a sum and
// an edge check, with a further check per edge emitted and a tail and a next
// state per histogram; the walk zeroes every bin it reads and clears the
// totals at its end. After reset a clearing pass over max(4*(MAX_ET+1),
// 3*(MAX_ETA_STEP+1)) addresses zeroes the rams, during which obj_stall
// stays high. Counters are 24 bits and saturate.
module equal_population_bin_edges import epbe_pkg::*; #(
	parameter int MAX_ET       = 200,
	parameter int MAX_ETA_STEP = 200,
	parameter int NUM_BINS     = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// object beats
	input  wire logic obj_valid,
	output logic      obj_stall,
	input  wire obj_t obj,
	// edge result beats
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);
	logic   cmd_valid;
	cmd_t   cmd;
	bstat_t bst;

	// range check and command queue
	epbe_front #(
		.MAX_ET(MAX_ET), .MAX_ETA_STEP(MAX_ETA_STEP)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.obj_valid(obj_valid), .obj_stall(obj_stall), .obj(obj),
		.cmd_valid(cmd_valid), .cmd(cmd), .bst(bst)
	);

	// histogram update, edge walk and output register
	epbe_back #(
		.MAX_ET(MAX_ET), .MAX_ETA_STEP(MAX_ETA_STEP), .NUM_BINS(NUM_BINS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .bst(bst),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// back never takes from an empty queue
	a_take_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		bst.take |-> cmd_valid)
		else $error("command taken from empty queue");

	// a pending command is not lost while the back is busy
	a_cmd_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !bst.take |=> cmd_valid)
		else $error("queued command vanished");

	// no object beat gets in while the rams are being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		bst.clearing |-> obj_stall)
		else $error("object accepted during clearing pass");
endmodule
`default_nettype wire

// ===== rtl/core/epbe_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module epbe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 804
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/epbe_front.sv =====
// front part: takes object beats, drops out-of-range objects, queues commands
// depends on epbe_pkg
`default_nettype none
module epbe_front import epbe_pkg::*; #(
	parameter int MAX_ET       = 200,
	parameter int MAX_ETA_STEP = 200
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   obj_valid,
	output logic        obj_stall,
	input  wire obj_t   obj,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  wire bstat_t bst
);
	localparam logic [11:0] ET_LIM  = 12'(MAX_ET);
	localparam logic [9:0]  ETA_LIM = 10'(MAX_ETA_STEP);

	cmd_t       queue_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       in_range, push, pop;
	cmd_t       new_cmd;

	assign in_range = (obj.et_ceil <= ET_LIM) &&
		((obj.obj_class == CLS_NEUTRINO) || (obj.eta_ceil <= ETA_LIM));
	assign obj_stall = bst.clearing || (cnt_q == 2'd2);
	assign push = obj_valid && !obj_stall && ((obj.func == FUNC_FINISH) || in_range);
	assign pop = bst.take && cmd_valid;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = queue_q[rp_q];

	always_comb begin
		new_cmd.func      = obj.func;
		new_cmd.obj_class = obj.obj_class;
		new_cmd.et_bin    = obj.et_ceil[BIN_W-1:0];
		new_cmd.eta_bin   = obj.eta_ceil[BIN_W-1:0];
		new_cmd.eta_en    = (obj.obj_class != CLS_NEUTRINO);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wp_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/epbe_back.sv =====
// back part: histogram updates and the edge walk, output register
// depends on epbe_pkg and epbe_ram
`default_nettype none
module epbe_back import epbe_pkg::*; #(
	parameter int MAX_ET       = 200,
	parameter int MAX_ETA_STEP = 200,
	parameter int NUM_BINS     = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output bstat_t    bst,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);
	localparam int ET_LEN    = MAX_ET + 1;
	localparam int ETA_LEN   = MAX_ETA_STEP + 1;
	localparam int ET_DEPTH  = 4 * ET_LEN;
	localparam int ETA_DEPTH = 3 * ETA_LEN;
	localparam int ET_AW     = $clog2(ET_DEPTH);
	localparam int ETA_AW    = $clog2(ETA_DEPTH);
	localparam int CLR_DEPTH = (ET_DEPTH > ETA_DEPTH) ? ET_DEPTH : ETA_DEPTH;
	localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
	localparam logic [IDX_W-1:0] NB   = IDX_W'(NUM_BINS);
	localparam logic [BIN_W-1:0] ET_LAST  = BIN_W'(ET_LEN - 1);
	localparam logic [BIN_W-1:0] ETA_LAST = BIN_W'(ETA_LEN - 1);
	localparam int PROD_W = SUM_W + IDX_W;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_ADD_WR = 8'b0000_0100,
		ST_WK_RD  = 8'b0000_1000,
		ST_WK_ACC = 8'b0001_0000,
		ST_WK_CHK = 8'b0010_0000,
		ST_WK_TL  = 8'b0100_0000,
		ST_WK_NX  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [CLR_W-1:0]  clr_q;
	cmd_t              add_q;
	logic [1:0]        cls_q;
	logic              axis_q;
	logic [BIN_W-1:0]  j_q;
	logic [IDX_W-1:0]  i_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  tot_q [4];
	logic              out_valid_q;
	res_t              out_q;

	logic              et_we, eta_we;
	logic [ET_AW-1:0]  et_waddr, et_raddr, et_cmd_addr, et_add_addr, et_walk_addr;
	logic [ETA_AW-1:0] eta_waddr, eta_raddr, eta_cmd_addr, eta_add_addr, eta_walk_addr;
	logic [CNT_W-1:0]  et_wdata, eta_wdata, et_rdata, eta_rdata, rd_cnt, total;
	logic [PROD_W-1:0] lhs, rhs;
	logic              can_emit, hit, emit, seg_last, bin_last;
	res_t              emit_res;

	epbe_ram #(.WIDTH(CNT_W), .DEPTH(ET_DEPTH)) u_et_ram (
		.clk(clk), .we(et_we), .waddr(et_waddr), .wdata(et_wdata),
		.raddr(et_raddr), .rdata(et_rdata)
	);
	epbe_ram #(.WIDTH(CNT_W), .DEPTH(ETA_DEPTH)) u_eta_ram (
		.clk(clk), .we(eta_we), .waddr(eta_waddr), .wdata(eta_wdata),
		.raddr(eta_raddr), .rdata(eta_rdata)
	);

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// address of class row plus bin
	assign et_cmd_addr   = ET_AW'(cmd.obj_class) * ET_AW'(ET_LEN) + ET_AW'(cmd.et_bin);
	assign et_add_addr   = ET_AW'(add_q.obj_class) * ET_AW'(ET_LEN) + ET_AW'(add_q.et_bin);
	assign et_walk_addr  = ET_AW'(cls_q) * ET_AW'(ET_LEN) + ET_AW'(j_q);
	assign eta_cmd_addr  = ETA_AW'(cmd.obj_class) * ETA_AW'(ETA_LEN) + ETA_AW'(cmd.eta_bin);
	assign eta_add_addr  = ETA_AW'(add_q.obj_class) * ETA_AW'(ETA_LEN) + ETA_AW'(add_q.eta_bin);
	assign eta_walk_addr = ETA_AW'(cls_q) * ETA_AW'(ETA_LEN) + ETA_AW'(j_q);

	assign rd_cnt   = (axis_q == AXIS_ETA) ? eta_rdata : et_rdata;
	assign total    = tot_q[cls_q];
	assign lhs      = PROD_W'(sum_q) * PROD_W'(NUM_BINS);
	assign rhs      = PROD_W'(i_q) * PROD_W'(total);
	assign hit      = (i_q != NB) && (lhs > rhs);
	assign can_emit = !out_valid_q || !res_stall;
	assign seg_last = (cls_q == CLS_NEUTRINO);
	assign bin_last = (axis_q == AXIS_ETA) ? (j_q == ETA_LAST) : (j_q == ET_LAST);

	always_comb begin
		emit = 1'b0;
		emit_res.edge_class = cls_q;
		emit_res.edge_axis  = axis_q;
		emit_res.edge_index = i_q;
		emit_res.edge_value = '0;
		emit_res.last_edge  = seg_last && (i_q == NB - 1'b1);
		if (state_q == ST_WK_CHK && hit && can_emit) begin
			emit = 1'b1;
			emit_res.edge_value = j_q;
		end else if (state_q == ST_WK_TL && i_q != NB && can_emit) begin
			emit = 1'b1;
		end
	end

	always_comb begin
		et_we     = 1'b0;
		eta_we    = 1'b0;
		et_waddr  = et_walk_addr;
		eta_waddr = eta_walk_addr;
		et_wdata  = '0;
		eta_wdata = '0;
		et_raddr  = et_walk_addr;
		eta_raddr = eta_walk_addr;
		bst.take     = 1'b0;
		bst.clearing = (state_q == ST_CLEAR);
		unique case (state_q)
			ST_CLEAR: begin
				et_we     = (clr_q < CLR_W'(ET_DEPTH));
				eta_we    = (clr_q < CLR_W'(ETA_DEPTH));
				et_waddr  = ET_AW'(clr_q);
				eta_waddr = ETA_AW'(clr_q);
			end
			ST_IDLE: begin
				bst.take  = cmd_valid;
				et_raddr  = et_cmd_addr;
				eta_raddr = eta_cmd_addr;
			end
			ST_ADD_WR: begin
				et_we     = 1'b1;
				et_waddr  = et_add_addr;
				et_wdata  = bump(et_rdata);
				eta_we    = add_q.eta_en;
				eta_waddr = eta_add_addr;
				eta_wdata = bump(eta_rdata);
			end
			ST_WK_ACC: begin
				// zero each bin once it has been summed
				et_we  = (axis_q == AXIS_ET);
				eta_we = (axis_q == AXIS_ETA);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			add_q <= cmd;
		end
		if (emit) begin
			out_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cls_q       <= '0;
			axis_q      <= AXIS_ET;
			j_q         <= '0;
			i_q         <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				tot_q[k] <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.func == FUNC_FINISH) begin
							cls_q   <= '0;
							axis_q  <= AXIS_ET;
							j_q     <= '0;
							i_q     <= IDX_W'(1);
							sum_q   <= '0;
							state_q <= ST_WK_RD;
						end else begin
							state_q <= ST_ADD_WR;
						end
					end
				end
				ST_ADD_WR: begin
					tot_q[add_q.obj_class] <= bump(tot_q[add_q.obj_class]);
					state_q <= ST_IDLE;
				end
				ST_WK_RD: begin
					state_q <= ST_WK_ACC;
				end
				ST_WK_ACC: begin
					sum_q   <= sum_q + SUM_W'(rd_cnt);
					state_q <= ST_WK_CHK;
				end
				ST_WK_CHK: begin
					if (hit) begin
						if (emit) begin
							i_q <= i_q + 1'b1;
						end
					end else if (bin_last) begin
						state_q <= ST_WK_TL;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_WK_RD;
					end
				end
				ST_WK_TL: begin
					// edges never reached read as zero
					if (i_q == NB) begin
						state_q <= ST_WK_NX;
					end else if (emit) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_WK_NX: begin
					j_q   <= '0;
					i_q   <= IDX_W'(1);
					sum_q <= '0;
					if (seg_last) begin
						for (int k = 0; k < 4; k++) begin
							tot_q[k] <= '0;
						end
						state_q <= ST_IDLE;
					end else begin
						if (axis_q == AXIS_ET) begin
							axis_q <= AXIS_ETA;
						end else begin
							axis_q <= AXIS_ET;
							cls_q  <= cls_q + 1'b1;
						end
						state_q <= ST_WK_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;
endmodule
`default_nettype wire
